[rtl/core/sat_pkg.sv]
// Shared types, sizes and codes for the sorted array table.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  localparam int DEPTH       = 128;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int FIELD_IDX_W = 7;
  localparam int FIELD_CNT_W = 8;
  localparam int VAL_W       = 32;

  // Four-way reduction tree, one register per level, stored as a flat heap.
  localparam int TREE_LVLS       = ($clog2(DEPTH) + 1) / 2;
  localparam int TREE_LEAVES     = 4 ** TREE_LVLS;
  localparam int TREE_NODES      = (4 * TREE_LEAVES - 1) / 3;
  localparam int TREE_FIRST_LEAF = (TREE_LEAVES - 1) / 3;
  localparam int TREE_CNT_W      = $clog2(TREE_LVLS + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_RANGE    = 2'd3;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [FIELD_IDX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [FIELD_IDX_W-1:0]  found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [FIELD_CNT_W-1:0]  entry_count;
  } rsp_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic                    del_en;
    logic                    read_mode;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic [FIELD_IDX_W-1:0]  index;
  } cell_ctl_t;

  // What the selected cell reports; all other cells report zero.
  typedef struct packed {
    logic                    hit;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] entry;
  } leaf_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_TREE,
    S_APPLY
  } state_t;

endpackage

`default_nettype wire

[rtl/core/sat_cell.sv]
// One cell of the table: holds one entry, compares it and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module sat_cell (
  input  logic                             clk,
  input  logic [sat_pkg::IDX_W-1:0]        cell_idx,
  input  sat_pkg::cell_ctl_t               ctl,
  input  logic                             prev_lt,
  input  logic signed [sat_pkg::VAL_W-1:0] prev_entry,
  input  logic signed [sat_pkg::VAL_W-1:0] next_entry,
  output logic                             lt,
  output logic signed [sat_pkg::VAL_W-1:0] entry,
  output sat_pkg::leaf_t                   leaf
);
  import sat_pkg::*;

  localparam int SEL_W = (IDX_W > FIELD_IDX_W) ? IDX_W : FIELD_IDX_W;

  logic eq;
  logic idx_hit;
  logic live;
  logic boundary;
  logic sel;

  assign live = CNT_W'(cell_idx) < ctl.count;

  // Entries are sorted, so the less-than flags form a run from cell zero and
  // the first cell without the flag is where the value belongs.
  assign boundary = !lt && prev_lt;
  assign sel      = ctl.read_mode ? idx_hit : boundary;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt      <= live && (entry < ctl.value);
      eq      <= live && (entry == ctl.value);
      idx_hit <= SEL_W'(cell_idx) == SEL_W'(ctl.index);
    end
    if (ctl.ins_en && !lt) begin
      entry <= prev_lt ? ctl.value : prev_entry;
    end else if (ctl.del_en && !lt) begin
      entry <= next_entry;
    end
  end

  always_comb begin
    leaf = '0;
    if (sel) begin
      leaf.hit   = eq;
      leaf.idx   = cell_idx;
      leaf.entry = entry;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sat_tree.sv]
// Registered four-way OR tree that gathers the report of the one selected cell.
`timescale 1ns / 1ps
`default_nettype none

module sat_tree (
  input  logic           clk,
  input  sat_pkg::leaf_t leaves [sat_pkg::DEPTH],
  output sat_pkg::leaf_t root
);
  import sat_pkg::*;

  leaf_t node [TREE_NODES];

  genvar j, k;

  generate
    for (j = 0; j < TREE_LEAVES; j++) begin : g_leaf
      if (j < DEPTH) begin : g_used
        assign node[TREE_FIRST_LEAF + j] = leaves[j];
      end else begin : g_pad
        assign node[TREE_FIRST_LEAF + j] = '0;
      end
    end

    for (k = 0; k < TREE_FIRST_LEAF; k++) begin : g_node
      always_ff @(posedge clk) begin
        node[k] <= leaf_t'(node[4*k + 1] | node[4*k + 2] | node[4*k + 3] | node[4*k + 4]);
      end
    end
  endgenerate

  assign root = node[0];

endmodule

`default_nettype wire

[rtl/core/sorted_array_table.sv]
// Top level of the sorted array table: sequencer, row of cells and gathering tree.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to DEPTH signed 32-bit entries in ascending order in a row of cells,
// one entry per cell, and serves insert, delete, search and read requests. A
// request is taken when the block is idle; every cell then compares its entry
// against the value in parallel, the one selected cell is gathered through a
// four-way OR tree with a register per level, and an insert or delete shifts
// every cell from its neighbour at once. A request passes the compare step,
// the TREE_LVLS = ceil(log4(DEPTH)) tree levels and the apply step before the
// next request is taken; the apply step waits while an earlier result is
// uncollected. The result waits in an output register, so a new request may
// be taken while the previous result has not yet been collected. Search and
// delete act on the lowest matching entry; an insert goes before all equal
// entries. Status is 0 ok, 1 full, 2 not found, 3 index out of range.

module sorted_array_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sat_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sat_pkg::rsp_t out_data
);
  import sat_pkg::*;

  localparam int CMP_W = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;

  state_t                  state;
  state_t                  state_next;
  logic [TREE_CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  req_t                    req;
  rsp_t                    rsp_next;
  logic                    apply_go;
  logic                    do_ins;
  logic                    do_del;
  cell_ctl_t               ctl;
  leaf_t                   root;

  logic                    lt_vec    [DEPTH];
  logic signed [VAL_W-1:0] entry_arr [DEPTH];
  leaf_t                   leaf_arr  [DEPTH];

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_TREE;
      S_TREE:  if (cnt == TREE_CNT_W'(TREE_LVLS - 1)) state_next = S_APPLY;
      S_APPLY: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    apply_go = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_APPLY: apply_go = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_TREE) ? cnt + 1'b1 : '0;
      if (apply_go) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (apply_go) begin
      out_data <= rsp_next;
    end
  end

  // Result and table update, from the gathered report.
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    unique case (req.op)
      OP_INSERT: begin
        if (count == CNT_W'(DEPTH)) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.found_index = FIELD_IDX_W'(root.idx);
          count_next           = count + 1'b1;
          do_ins               = 1'b1;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (!root.hit) begin
          rsp_next.status = ST_NOTFOUND;
        end else begin
          rsp_next.found_index = FIELD_IDX_W'(root.idx);
          if (req.op == OP_DELETE) begin
            count_next = count - 1'b1;
            do_del     = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (CMP_W'(req.index) >= CMP_W'(count)) begin
          rsp_next.status = ST_RANGE;
        end else begin
          rsp_next.found_index = req.index;
          rsp_next.read_value  = root.entry;
        end
      end
      default: ;
    endcase
    rsp_next.entry_count = FIELD_CNT_W'(count_next);
  end

  always_comb begin
    ctl           = '0;
    ctl.cmp_en    = (state == S_CMP);
    ctl.ins_en    = apply_go && do_ins;
    ctl.del_en    = apply_go && do_del;
    ctl.read_mode = (req.op == OP_READ);
    ctl.value     = req.value;
    ctl.count     = count;
    ctl.index     = req.index;
  end

  // Row of cells; the first cell sees a neighbour that is always less.
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                    prev_lt;
      logic signed [VAL_W-1:0] prev_entry;
      logic signed [VAL_W-1:0] next_entry;

      if (i == 0) begin : g_first
        assign prev_lt    = 1'b1;
        assign prev_entry = '0;
      end else begin : g_mid
        assign prev_lt    = lt_vec[i-1];
        assign prev_entry = entry_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign next_entry = '0;
      end else begin : g_inner
        assign next_entry = entry_arr[i+1];
      end

      sat_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_W'(i)),
        .ctl        (ctl),
        .prev_lt    (prev_lt),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .lt         (lt_vec[i]),
        .entry      (entry_arr[i]),
        .leaf       (leaf_arr[i])
      );
    end
  endgenerate

  sat_tree u_tree (
    .clk    (clk),
    .leaves (leaf_arr),
    .root   (root)
  );

endmodule

`default_nettype wire
